FILE: sv/srd_pkg.sv
// srd_pkg: shared types and constants for the socket report deframer.
// No dependencies; imported by srd_parser, srd_out_stage and socket_report_deframer.

package srd_pkg;

    localparam int BYTE_W      = 8;
    localparam int WORD_W      = 32;
    localparam int WINDOW_W    = 64;
    localparam int FIELD_POS_W = 4;
    localparam int NL_COUNT_W  = 2;

    localparam logic [WINDOW_W-1:0]   HEADER_TEXT = 64'h2B53_4B54_5250_543D; // "+SKTRPT="
    localparam logic [BYTE_W-1:0]     CH_COMMA    = 8'h2C;
    localparam logic [BYTE_W-1:0]     CH_NEWLINE  = 8'h0A;
    localparam logic [WORD_W-1:0]     CH_ZERO     = 32'd48;
    localparam logic [NL_COUNT_W-1:0] NL_TARGET   = 2'd2;

    // Parser mode, one-hot
    typedef enum logic [4:0] {
        MODE_HUNT    = 5'b00001,
        MODE_SOCKET  = 5'b00010,
        MODE_LENGTH  = 5'b00100,
        MODE_NEWLINE = 5'b01000,
        MODE_PAYLOAD = 5'b10000
    } srd_mode_t;

    // One result beat
    typedef struct packed {
        logic [BYTE_W-1:0] payload_byte;
        logic [WORD_W-1:0] socket_number;
        logic              last_byte;
    } srd_result_t;

endpackage

FILE: sv/socket_report_deframer.sv
// socket_report_deframer: top level of the modem socket report deframer.
// Depends on srd_pkg, srd_parser and srd_out_stage.
//
//  channel | handshake           | payload
//  --------+---------------------+-------------------------------------------
//  in      | in_valid / in_stall | rx_byte
//  out     | out_valid/out_stall | payload_byte, socket_number, last_byte
//
// One byte per cycle sustained while no payload byte waits on a stalled output.
// A byte taken is held in the input register and parsed from there; if it is a
// payload byte, it is loaded into the output register and appears from there.
// Reset (rst_n low, asynchronous) clears the parser to the header hunt and
// empties both registers.
// Only a payload byte waits on a full, stalled output register; header and
// field bytes keep moving even while a result beat is held.

module socket_report_deframer #(
    parameter int MAX_FIELD_CHARS = 9
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [srd_pkg::BYTE_W-1:0]  rx_byte,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [srd_pkg::BYTE_W-1:0]  payload_byte,
    output logic [srd_pkg::WORD_W-1:0]  socket_number,
    output logic                        last_byte
);
    import srd_pkg::*;

    // input register
    logic              in_valid_reg, in_valid_next;
    logic [BYTE_W-1:0] byte_reg;

    logic              produces;
    logic              room;
    logic              advance;
    logic              in_accept;
    srd_result_t       result;
    srd_result_t       held;

    // a byte moves on unless it carries a result and the output has no room
    assign advance   = in_valid_reg && (!produces || room);
    assign in_stall  = in_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_accept)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
            byte_reg <= rx_byte;
    end

    srd_parser #(
        .MAX_FIELD_CHARS (MAX_FIELD_CHARS)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .data_byte (byte_reg),
        .produces  (produces),
        .result    (result)
    );

    srd_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance && produces),
        .result    (result),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .room      (room),
        .held      (held)
    );

    assign payload_byte  = held.payload_byte;
    assign socket_number = held.socket_number;
    assign last_byte     = held.last_byte;

endmodule

FILE: sv/srd_parser.sv
// srd_parser: header hunt, field accumulation and payload counting state.
// Depends on srd_pkg. Steps once per registered input byte.

module srd_parser #(
    parameter int MAX_FIELD_CHARS = 9
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step,
    input  logic [srd_pkg::BYTE_W-1:0]  data_byte,
    output logic                        produces,
    output srd_pkg::srd_result_t        result
);
    import srd_pkg::*;

    srd_mode_t               mode_reg,     mode_next;
    logic [WINDOW_W-1:0]     window_reg,   window_next;
    logic [FIELD_POS_W-1:0]  field_reg,    field_next;
    logic [WORD_W-1:0]       socket_reg,   socket_next;
    logic [WORD_W-1:0]       length_reg,   length_next;
    logic [NL_COUNT_W-1:0]   nl_reg,       nl_next;
    logic [WORD_W-1:0]       count_reg,    count_next;

    logic [WINDOW_W-1:0]     window_shift;
    logic [WORD_W-1:0]       field_acc;
    logic [WORD_W-1:0]       acc_update;
    logic [NL_COUNT_W-1:0]   nl_inc;
    logic [WORD_W-1:0]       count_inc;
    logic                    is_last;
    logic                    field_full;

    assign window_shift = {window_reg[WINDOW_W-BYTE_W-1:0], data_byte};
    assign field_acc    = (mode_reg == MODE_SOCKET) ? socket_reg : length_reg;
    // acc * 10 + byte - '0', wrapping
    assign acc_update   = {field_acc[WORD_W-4:0], 3'b000} + {field_acc[WORD_W-2:0], 1'b0}
                        + {{(WORD_W-BYTE_W){1'b0}}, data_byte} - CH_ZERO;
    assign nl_inc       = nl_reg + NL_COUNT_W'(1);
    assign count_inc    = count_reg + WORD_W'(1);
    assign is_last      = (count_inc == length_reg);
    assign field_full   = (field_reg >= FIELD_POS_W'(MAX_FIELD_CHARS));

    assign produces = (mode_reg == MODE_PAYLOAD);
    assign result   = '{payload_byte: data_byte, socket_number: socket_reg, last_byte: is_last};

    always_comb
    begin
        mode_next   = mode_reg;
        window_next = window_reg;
        field_next  = field_reg;
        socket_next = socket_reg;
        length_next = length_reg;
        nl_next     = nl_reg;
        count_next  = count_reg;
        if (step)
        begin
            unique case (mode_reg) inside
                MODE_SOCKET, MODE_LENGTH:
                begin
                    if (data_byte == CH_COMMA)
                    begin
                        mode_next  = (mode_reg == MODE_SOCKET) ? MODE_LENGTH : MODE_NEWLINE;
                        field_next = '0;
                    end
                    else if (field_full)
                    begin
                        mode_next   = MODE_HUNT;
                        window_next = '0;
                        field_next  = '0;
                        nl_next     = '0;
                        count_next  = '0;
                    end
                    else
                    begin
                        if (mode_reg == MODE_SOCKET)
                            socket_next = acc_update;
                        else
                            length_next = acc_update;
                        field_next = field_reg + FIELD_POS_W'(1);
                    end
                end
                MODE_NEWLINE:
                begin
                    if (data_byte == CH_NEWLINE)
                    begin
                        nl_next = nl_inc;
                        if (nl_inc == NL_TARGET)
                        begin
                            if (length_reg == '0)
                            begin
                                mode_next   = MODE_HUNT;
                                window_next = '0;
                                field_next  = '0;
                                nl_next     = '0;
                                count_next  = '0;
                            end
                            else
                            begin
                                mode_next  = MODE_PAYLOAD;
                                count_next = '0;
                            end
                        end
                    end
                end
                MODE_PAYLOAD:
                begin
                    count_next = count_inc;
                    if (is_last)
                    begin
                        mode_next   = MODE_HUNT;
                        window_next = '0;
                        field_next  = '0;
                        nl_next     = '0;
                        count_next  = '0;
                    end
                end
                default:
                begin
                    // hunt, and any stray code
                    if (window_shift == HEADER_TEXT)
                    begin
                        mode_next   = MODE_SOCKET;
                        window_next = '0;
                        field_next  = '0;
                        nl_next     = '0;
                        count_next  = '0;
                        socket_next = '0;
                        length_next = '0;
                    end
                    else
                    begin
                        mode_next   = MODE_HUNT;
                        window_next = window_shift;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_HUNT;
            window_reg <= '0;
            field_reg  <= '0;
            socket_reg <= '0;
            length_reg <= '0;
            nl_reg     <= '0;
            count_reg  <= '0;
        end
        else
        begin
            mode_reg   <= mode_next;
            window_reg <= window_next;
            field_reg  <= field_next;
            socket_reg <= socket_next;
            length_reg <= length_next;
            nl_reg     <= nl_next;
            count_reg  <= count_next;
        end
    end

    // window only holds bytes while hunting
    a_window_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg != MODE_HUNT) |-> (window_reg == '0))
        else $error("header window not clear outside hunt");

    // final payload beat always returns to the hunt
    a_last_to_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        (step && produces && is_last) |=> (mode_reg == MODE_HUNT))
        else $error("no return to hunt after last payload byte");

    // field position never passes the limit
    a_field_limit: assert property (@(posedge clk) disable iff (!rst_n)
        field_reg <= FIELD_POS_W'(MAX_FIELD_CHARS))
        else $error("field position beyond limit");

endmodule

FILE: sv/srd_out_stage.sv
// srd_out_stage: result register on the output channel.
// Depends on srd_pkg. Loads a result beat from the parser, holds it while stalled.

module srd_out_stage (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  srd_pkg::srd_result_t  result,
    input  logic                  out_stall,
    output logic                  out_valid,
    output logic                  room,
    output srd_pkg::srd_result_t  held
);
    import srd_pkg::*;

    logic        valid_reg, valid_next;
    srd_result_t data_reg;

    assign room      = !valid_reg || !out_stall;
    assign out_valid = valid_reg;
    assign held      = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (valid_reg && !out_stall)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= result;
    end

endmodule

FILE: test/tb_socket_report_deframer.sv
// tb_socket_report_deframer: self-checking bench for the socket report deframer.
// Sends report frames, broken frames and line noise, predicts every payload beat.
// Depends on srd_pkg and socket_report_deframer.

module tb_socket_report_deframer;

    import srd_pkg::*;

    localparam int FIELD_LIMIT  = 9;     // characters allowed before a field's comma
    localparam int ITEM_TARGET  = 1550;  // bytes to offer before the run winds down
    localparam int CALM_BYTES   = 250;   // closing stretch with no idling on either side
    localparam int LONG_HOLD    = 300;   // one long receiver hold-off, in cycles
    localparam int DRAIN_CYCLES = 8;     // margin after the last delivered beat
    localparam int STALL_LIMIT  = 2500;  // cycles with no beat moving before giving up
    localparam int N_DIRECTED   = 29;

    // One row of the directed table; beat is only meaningful when typed is set
    typedef struct packed {
        logic [BYTE_W-1:0] rx;
        logic              typed;
        srd_result_t       beat;
    } stim_row_t;

    stim_row_t directed_rows [N_DIRECTED] = '{
        // header, socket "/" wraps to all ones, length 2, a stray byte before the newlines
        '{"+", 1'b0, '0}, '{"S", 1'b0, '0}, '{"K", 1'b0, '0}, '{"T", 1'b0, '0},
        '{"R", 1'b0, '0}, '{"P", 1'b0, '0}, '{"T", 1'b0, '0}, '{"=", 1'b0, '0},
        '{"/", 1'b0, '0}, '{CH_COMMA, 1'b0, '0}, '{"2", 1'b0, '0}, '{CH_COMMA, 1'b0, '0},
        '{8'h00, 1'b0, '0}, '{CH_NEWLINE, 1'b0, '0}, '{CH_NEWLINE, 1'b0, '0},
        '{8'hFF, 1'b1, '{8'hFF, 32'hFFFF_FFFF, 1'b0}},
        '{8'h00, 1'b1, '{8'h00, 32'hFFFF_FFFF, 1'b1}},
        // header, both fields empty: zero length, straight back to the hunt
        '{"+", 1'b0, '0}, '{"S", 1'b0, '0}, '{"K", 1'b0, '0}, '{"T", 1'b0, '0},
        '{"R", 1'b0, '0}, '{"P", 1'b0, '0}, '{"T", 1'b0, '0}, '{"=", 1'b0, '0},
        '{CH_COMMA, 1'b0, '0}, '{CH_COMMA, 1'b0, '0},
        '{CH_NEWLINE, 1'b0, '0}, '{CH_NEWLINE, 1'b0, '0}
    };

    logic              clk;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_stall;
    logic [BYTE_W-1:0] rx_byte   = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [BYTE_W-1:0] payload_byte;
    logic [WORD_W-1:0] socket_number;
    logic              last_byte;

    // Predicted parser state
    srd_mode_t              p_mode;
    logic [WINDOW_W-1:0]    p_window;
    logic [FIELD_POS_W-1:0] p_chars;
    logic [WORD_W-1:0]      p_socket;
    logic [WORD_W-1:0]      p_length;
    logic [NL_COUNT_W-1:0]  p_newlines;
    logic [WORD_W-1:0]      p_emitted;

    srd_result_t payload_due [$];   // payload beats predicted but not yet seen

    int bytes_sent     = 0;
    int frames_sent    = 0;
    int beats_checked  = 0;
    int last_marks     = 0;
    int mismatch_count = 0;
    int hold_request   = 0;         // sender asks the receiver for a long hold-off
    bit calm_tail      = 1'b0;

    socket_report_deframer #(
        .MAX_FIELD_CHARS (FIELD_LIMIT)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .payload_byte  (payload_byte),
        .socket_number (socket_number),
        .last_byte     (last_byte)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ---------------------------------------------------------------- predictor

    // Back to the hunt; socket and length values survive until the next header
    function automatic void restart_hunt();
        p_mode     = MODE_HUNT;
        p_window   = '0;
        p_chars    = '0;
        p_newlines = '0;
        p_emitted  = '0;
    endfunction

    // Advances the predicted parser by one byte; returns 1 when a payload beat results
    function automatic bit deframe_byte(input logic [BYTE_W-1:0] b, output srd_result_t beat);
        logic [WORD_W-1:0] digit;
        logic              is_last;
        beat  = '0;
        digit = {{(WORD_W-BYTE_W){1'b0}}, b} - CH_ZERO;   // any byte counts, not only digits
        case (p_mode) inside
            MODE_SOCKET, MODE_LENGTH:
            begin
                if (b == CH_COMMA)
                begin
                    p_mode  = (p_mode == MODE_SOCKET) ? MODE_LENGTH : MODE_NEWLINE;
                    p_chars = '0;
                end
                else if (p_chars >= FIELD_LIMIT)
                    restart_hunt();                       // field too long
                else
                begin
                    if (p_mode == MODE_SOCKET)
                        p_socket = p_socket * 32'd10 + digit;
                    else
                        p_length = p_length * 32'd10 + digit;
                    p_chars = p_chars + 4'd1;
                end
                return 1'b0;
            end
            MODE_NEWLINE:
            begin
                // anything but a newline is skipped here
                if (b == CH_NEWLINE)
                begin
                    p_newlines = p_newlines + 2'd1;
                    if (p_newlines == NL_TARGET)
                    begin
                        if (p_length == '0)
                            restart_hunt();
                        else
                        begin
                            p_mode    = MODE_PAYLOAD;
                            p_emitted = '0;
                        end
                    end
                end
                return 1'b0;
            end
            MODE_PAYLOAD:
            begin
                is_last   = (p_emitted + 32'd1) == p_length;
                beat      = '{payload_byte: b, socket_number: p_socket, last_byte: is_last};
                p_emitted = p_emitted + 32'd1;
                if (is_last)
                    restart_hunt();
                return 1'b1;
            end
            default:
            begin
                p_window = {p_window[WINDOW_W-BYTE_W-1:0], b};
                if (p_window == HEADER_TEXT)
                begin
                    restart_hunt();
                    p_mode   = MODE_SOCKET;
                    p_socket = '0;
                    p_length = '0;
                end
                else
                    p_mode = MODE_HUNT;
                return 1'b0;
            end
        endcase
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                   input logic [WORD_W-1:0] want);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("ERROR: beat %0d, %s: got 0x%0h, want 0x%0h",
                     beats_checked, what, got, want);
    endtask

    always @(posedge clk)
    begin : payload_check
        srd_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            beats_checked++;
            if (last_byte)
                last_marks++;
            if (payload_due.size() == 0)
                report_mismatch("beat with nothing expected, payload_byte",
                                WORD_W'(payload_byte), '0);
            else
            begin
                want = payload_due.pop_front();
                if (payload_byte !== want.payload_byte)
                    report_mismatch("payload_byte", WORD_W'(payload_byte),
                                    WORD_W'(want.payload_byte));
                if (socket_number !== want.socket_number)
                    report_mismatch("socket_number", socket_number, want.socket_number);
                if (last_byte !== want.last_byte)
                    report_mismatch("last_byte", WORD_W'(last_byte), WORD_W'(want.last_byte));
            end
        end
    end

    // ---------------------------------------------------------------- receiver

    // Random stall bursts, one long hold-off on request, none in the closing stretch
    initial
    begin : receiver
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                stall_left   = hold_request;
                hold_request = 0;
            end
            else if (stall_left == 0 && !calm_tail && $urandom_range(0, 9) == 0)
                stall_left = $urandom_range(1, 19);
            out_stall <= (stall_left > 0);
            if (stall_left > 0)
                stall_left--;
        end
    end

    // ---------------------------------------------------------------- sender

    // Offers one byte, waits for it to be taken, then predicts from it.
    // A typed row supplies its own expected beat.
    task automatic send_byte(input logic [BYTE_W-1:0] b, input bit typed = 1'b0,
                             input srd_result_t typed_beat = '0);
        srd_result_t beat;
        bit          has_beat;
        @(negedge clk);
        if (!calm_tail && $urandom_range(0, 11) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (in_stall);
        has_beat = deframe_byte(b, beat);
        if (typed)
            payload_due.push_back(typed_beat);
        else if (has_beat)
            payload_due.push_back(beat);
        bytes_sent++;
    endtask

    task automatic send_string(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    // First n bytes of the header text
    task automatic send_header_part(input int n);
        for (int i = 0; i < n; i++)
            send_byte(HEADER_TEXT[WINDOW_W-1-BYTE_W*i -: BYTE_W]);
    endtask

    function automatic logic [BYTE_W-1:0] random_except(input logic [BYTE_W-1:0] avoid);
        logic [BYTE_W-1:0] c;
        do
            c = BYTE_W'($urandom_range(0, 255));
        while (c == avoid);
        return c;
    endfunction

    // Field text: digits half the time, otherwise any byte but a comma
    function automatic logic [BYTE_W-1:0] field_char();
        if ($urandom_range(0, 1) == 0)
            return BYTE_W'(CH_ZERO + $urandom_range(0, 9));
        return random_except(CH_COMMA);
    endfunction

    // Line noise, sometimes a header cut short
    task automatic send_noise();
        int n;
        int k;
        n = $urandom_range(1, 12);
        k = $urandom_range(1, 7);
        if ($urandom_range(0, 2) == 0)
            send_header_part(k);
        repeat (n) send_byte(BYTE_W'($urandom_range(0, 255)));
    endtask

    // One report. fixed_len >= 0 gives a clean frame of that length; otherwise the
    // fields take random shapes, some of them too long so that the frame aborts.
    task automatic send_frame(input int fixed_len);
        int n;
        int len_val;
        int shape;
        bit clean;
        clean = (fixed_len >= 0);
        frames_sent++;
        send_header_part(BYTE_W);

        // socket field: empty, short, exactly full, or one too many
        shape = clean ? 4 : $urandom_range(0, 7);
        case (shape)
            0:       n = 0;
            1:       n = FIELD_LIMIT;
            2:       n = FIELD_LIMIT + 1;
            default: n = $urandom_range(1, 4);
        endcase
        repeat (n) send_byte(field_char());
        if (n > FIELD_LIMIT)
            return;                                       // already back in the hunt
        send_byte(CH_COMMA);

        // length field: kept small so every frame closes
        if (clean)
            len_val = fixed_len;
        else if ($urandom_range(0, 7) == 0)
            len_val = 0;
        else if ($urandom_range(0, 15) == 0)
            len_val = $urandom_range(13, 40);
        else
            len_val = $urandom_range(1, 12);
        shape = clean ? 4 : $urandom_range(0, 7);
        case (shape)
            0:
            begin
                if (len_val != 0)
                    send_string($sformatf("%0d", len_val));
            end
            1: send_string($sformatf("%09d", len_val));   // comma after a full field
            2:
            begin
                // one non-digit character carries the whole value
                len_val = $urandom_range(10, 30);
                send_byte(BYTE_W'(len_val) + CH_ZERO[BYTE_W-1:0]);
            end
            3:
            begin
                repeat (FIELD_LIMIT + 1) send_byte("0");
                return;
            end
            default: send_string($sformatf("%0d", len_val));
        endcase
        send_byte(CH_COMMA);

        // stray bytes may sit before and between the newlines
        repeat (clean ? 0 : $urandom_range(0, 2)) send_byte(random_except(CH_NEWLINE));
        send_byte(CH_NEWLINE);
        repeat (clean ? 0 : $urandom_range(0, 1)) send_byte(random_except(CH_NEWLINE));
        send_byte(CH_NEWLINE);
        repeat (len_val) send_byte(BYTE_W'($urandom_range(0, 255)));
    endtask

    // Holds the input idle until every predicted beat has come out
    task automatic wait_all_delivered();
        @(negedge clk);
        in_valid <= 1'b0;
        while (payload_due.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin : stimulus
        int pick;
        restart_hunt();
        p_socket = '0;
        p_length = '0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_byte(directed_rows[i].rx, directed_rows[i].typed, directed_rows[i].beat);

        while (bytes_sent < ITEM_TARGET)
        begin
            if (bytes_sent > ITEM_TARGET - CALM_BYTES)
                calm_tail = 1'b1;
            pick = $urandom_range(0, 5);
            if (frames_sent == 6)
            begin
                // long hold-off against a long frame: the block fills and stalls its input
                hold_request = LONG_HOLD;
                send_frame(48);
                wait_all_delivered();
            end
            else if (pick == 0)
                send_noise();
            else
            begin
                send_frame(-1);
                if (frames_sent % 10 == 0)
                    wait_all_delivered();
            end
        end

        wait_all_delivered();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d input bytes over %0d report headers, %0d payload beats checked,",
                 bytes_sent, frames_sent, beats_checked);
        $display("%0d frame ends marked, with aborted fields, empty fields and zero lengths.",
                 last_marks);
        if (mismatch_count == 0 && payload_due.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Ends the run if no beat moves on either side for too long
    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Timeout: no beat moved for %0d cycles", STALL_LIMIT);
        $display("Mismatches found");
        $finish;
    end

endmodule
